// File: design/hsv_to_rgb_pixel_top_assert.svh
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel_top assertion macros
// Shorthand for clocked, reset-qualified checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_PIXEL_TOP_ASSERT_SVH
`define HSV_TO_RGB_PIXEL_TOP_ASSERT_SVH

// Same-cycle implication: when ante holds, cons holds in that cycle.
`define HSVP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons holds in the following cycle.
`define HSVP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/hsvp_pkg.sv
// ----------------------------------------------------------------------------
// hsvp_pkg
// Shared widths, sector codes and pipeline control types for HSV to RGB.
// ----------------------------------------------------------------------------
package hsvp_pkg;

  localparam int IN_W   = 17;  // hue, saturation, brightness
  localparam int CHAN_W = 8;   // red, green, blue, alpha
  localparam int H6_W   = 20;  // hue * 6 fits in 20 bits

  // Sector of the color wheel; 5 also covers every sector beyond it.
  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } hsvp_sector_t;

  // Per-stage load enables of the pipeline.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } hsvp_adv_t;

endpackage

// File: design/hsvp_if.sv
// ----------------------------------------------------------------------------
// hsvp_in_if / hsvp_out_if
// Valid/ready channels carrying an HSV pixel in and an RGB pixel out.
// ----------------------------------------------------------------------------
interface hsvp_in_if;
  import hsvp_pkg::*;

  logic              valid;
  logic              ready;
  logic [IN_W-1:0]   hue;
  logic [IN_W-1:0]   saturation;
  logic [IN_W-1:0]   brightness;
  logic [CHAN_W-1:0] alpha_in;

  modport source (output valid, hue, saturation, brightness, alpha_in, input ready);
  modport sink   (input valid, hue, saturation, brightness, alpha_in, output ready);
endinterface

interface hsvp_out_if;
  import hsvp_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic [CHAN_W-1:0] alpha_out;

  modport source (output valid, red, green, blue, alpha_out, input ready);
  modport sink   (input valid, red, green, blue, alpha_out, output ready);
endinterface

// File: design/hsvp_front.sv
// ----------------------------------------------------------------------------
// hsvp_front
// Stage 1: scale hue by 6, split it into sector and fraction.
// ----------------------------------------------------------------------------
module hsvp_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       adv_s1,
  input  logic [hsvp_pkg::IN_W-1:0]   hue,
  input  logic [hsvp_pkg::IN_W-1:0]   saturation,
  input  logic [hsvp_pkg::IN_W-1:0]   brightness,
  input  logic [hsvp_pkg::CHAN_W-1:0] alpha_in,
  output hsvp_pkg::hsvp_sector_t      sec,
  output logic [FRAC_BITS-1:0]       frac,
  output logic [hsvp_pkg::IN_W-1:0]   sat,
  output logic [hsvp_pkg::IN_W-1:0]   val,
  output logic [hsvp_pkg::CHAN_W-1:0] alpha
);
  import hsvp_pkg::*;

  localparam int WX = (H6_W > FRAC_BITS + 1) ? H6_W : FRAC_BITS + 1;

  logic [H6_W-1:0]   h6;
  logic [WX-1:0]     h6x;
  logic [WX-1:0]     sec_big;
  hsvp_sector_t      sec_nxt;
  hsvp_sector_t      sec_r;
  logic [FRAC_BITS-1:0] frac_r;
  logic [IN_W-1:0]   sat_r;
  logic [IN_W-1:0]   val_r;
  logic [CHAN_W-1:0] alpha_r;

  always_comb begin
    h6      = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
    h6x     = WX'(h6);
    sec_big = h6x >> FRAC_BITS;
    if (sec_big >= WX'(SEC_5)) begin
      sec_nxt = SEC_5;
    end else begin
      sec_nxt = hsvp_sector_t'(sec_big[2:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv_s1) begin
      sec_r   <= sec_nxt;
      frac_r  <= h6x[FRAC_BITS-1:0];
      sat_r   <= saturation;
      val_r   <= brightness;
      alpha_r <= alpha_in;
    end
  end

  assign sec   = sec_r;
  assign frac  = frac_r;
  assign sat   = sat_r;
  assign val   = val_r;
  assign alpha = alpha_r;
endmodule

// File: design/hsvp_terms.sv
// ----------------------------------------------------------------------------
// hsvp_terms
// Stages 2-3: s*f and s*(1-f), then the products v(1-s), v(1-sf), v(1-s(1-f)).
// ----------------------------------------------------------------------------
module hsvp_terms #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  hsvp_pkg::hsvp_adv_t         adv,
  input  hsvp_pkg::hsvp_sector_t      sec_in,
  input  logic [FRAC_BITS-1:0]       frac,
  input  logic [hsvp_pkg::IN_W-1:0]   sat,
  input  logic [hsvp_pkg::IN_W-1:0]   val_in,
  input  logic [hsvp_pkg::CHAN_W-1:0] alpha_in,
  output logic signed [19+((FRAC_BITS > hsvp_pkg::IN_W) ? FRAC_BITS : hsvp_pkg::IN_W):0] p,
  output logic signed [19+((FRAC_BITS > hsvp_pkg::IN_W) ? FRAC_BITS : hsvp_pkg::IN_W):0] q,
  output logic signed [19+((FRAC_BITS > hsvp_pkg::IN_W) ? FRAC_BITS : hsvp_pkg::IN_W):0] t,
  output logic [hsvp_pkg::IN_W-1:0]   val_out,
  output logic                       grey,
  output hsvp_pkg::hsvp_sector_t      sec_out,
  output logic [hsvp_pkg::CHAN_W-1:0] alpha_out
);
  import hsvp_pkg::*;

  localparam int DW = ((FRAC_BITS > IN_W) ? FRAC_BITS : IN_W) + 2;
  localparam int PW = IN_W + 1 + DW;
  localparam logic [DW-1:0] ONE_D =
    {{(DW - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  // stage 2
  logic [IN_W+FRAC_BITS-1:0] prod_sf;
  logic [FRAC_BITS:0]        omf;
  logic [IN_W+FRAC_BITS:0]   prod_sg;
  logic [IN_W-1:0]   sf_r, sg_r, sat2_r, val2_r;
  hsvp_sector_t      sec2_r;
  logic [CHAN_W-1:0] alpha2_r;

  // stage 3
  logic signed [DW-1:0] d_p, d_q, d_t;
  logic signed [IN_W:0] v_s;
  logic signed [PW-1:0] p_r, q_r, t_r;
  logic [IN_W-1:0]      val3_r;
  logic                 grey3_r;
  hsvp_sector_t         sec3_r;
  logic [CHAN_W-1:0]    alpha3_r;

  always_comb begin
    prod_sf = sat * frac;
    omf     = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac};
    prod_sg = sat * omf;
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      sf_r     <= prod_sf[FRAC_BITS +: IN_W];
      sg_r     <= prod_sg[FRAC_BITS +: IN_W];
      sat2_r   <= sat;
      val2_r   <= val_in;
      sec2_r   <= sec_in;
      alpha2_r <= alpha_in;
    end
  end

  always_comb begin
    d_p = $signed(ONE_D - {{(DW - IN_W){1'b0}}, sat2_r});
    d_q = $signed(ONE_D - {{(DW - IN_W){1'b0}}, sf_r});
    d_t = $signed(ONE_D - {{(DW - IN_W){1'b0}}, sg_r});
    v_s = $signed({1'b0, val2_r});
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      p_r      <= v_s * d_p;
      q_r      <= v_s * d_q;
      t_r      <= v_s * d_t;
      val3_r   <= val2_r;
      grey3_r  <= (sat2_r == '0);
      sec3_r   <= sec2_r;
      alpha3_r <= alpha2_r;
    end
  end

  assign p         = p_r;
  assign q         = q_r;
  assign t         = t_r;
  assign val_out   = val3_r;
  assign grey      = grey3_r;
  assign sec_out   = sec3_r;
  assign alpha_out = alpha3_r;
endmodule

// File: design/hsvp_chan.sv
// ----------------------------------------------------------------------------
// hsvp_chan
// Stages 4-5: convert each term to an 8-bit channel, then route by sector.
// ----------------------------------------------------------------------------
module hsvp_chan #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  hsvp_pkg::hsvp_adv_t         adv,
  input  logic signed [19+((FRAC_BITS > hsvp_pkg::IN_W) ? FRAC_BITS : hsvp_pkg::IN_W):0] p,
  input  logic signed [19+((FRAC_BITS > hsvp_pkg::IN_W) ? FRAC_BITS : hsvp_pkg::IN_W):0] q,
  input  logic signed [19+((FRAC_BITS > hsvp_pkg::IN_W) ? FRAC_BITS : hsvp_pkg::IN_W):0] t,
  input  logic [hsvp_pkg::IN_W-1:0]   val,
  input  logic                       grey,
  input  hsvp_pkg::hsvp_sector_t      sec,
  input  logic [hsvp_pkg::CHAN_W-1:0] alpha_in,
  output logic [hsvp_pkg::CHAN_W-1:0] red,
  output logic [hsvp_pkg::CHAN_W-1:0] green,
  output logic [hsvp_pkg::CHAN_W-1:0] blue,
  output logic [hsvp_pkg::CHAN_W-1:0] alpha_out
);
  import hsvp_pkg::*;

  localparam int DW = ((FRAC_BITS > IN_W) ? FRAC_BITS : IN_W) + 2;
  localparam int PW = IN_W + 1 + DW;

  logic [CHAN_W-1:0] cv_r, cp_r, cq_r, ct_r, alpha4_r;
  logic              grey4_r;
  hsvp_sector_t      sec4_r;
  logic [CHAN_W-1:0] red_nxt, green_nxt, blue_nxt;
  logic [CHAN_W-1:0] red_r, green_r, blue_r, alpha5_r;

  // floor(x * 255) >> 2F, zero for x <= 0, clamped at 255
  function automatic logic [CHAN_W-1:0] chan_wide(input logic signed [PW-1:0] x);
    logic [PW+7:0]     m;
    logic [PW+7:0]     y;
    logic [CHAN_W-1:0] c;
    m = {x, 8'h00} - {8'h00, x};
    y = m >> (2 * FRAC_BITS);
    if (x[PW-1] || (x == '0)) begin
      c = '0;
    end else if (|y[PW+7:CHAN_W]) begin
      c = '1;
    end else begin
      c = y[CHAN_W-1:0];
    end
    return c;
  endfunction

  // floor(v * 255) >> F, clamped at 255
  function automatic logic [CHAN_W-1:0] chan_val(input logic [IN_W-1:0] v);
    logic [IN_W+7:0]   m;
    logic [IN_W+7:0]   y;
    logic [CHAN_W-1:0] c;
    m = {v, 8'h00} - {8'h00, v};
    y = m >> FRAC_BITS;
    if (|y[IN_W+7:CHAN_W]) begin
      c = '1;
    end else begin
      c = y[CHAN_W-1:0];
    end
    return c;
  endfunction

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      cv_r     <= chan_val(val);
      cp_r     <= chan_wide(p);
      cq_r     <= chan_wide(q);
      ct_r     <= chan_wide(t);
      grey4_r  <= grey;
      sec4_r   <= sec;
      alpha4_r <= alpha_in;
    end
  end

  always_comb begin
    red_nxt   = cv_r;
    green_nxt = cv_r;
    blue_nxt  = cv_r;
    if (!grey4_r) begin
      case (sec4_r)
        SEC_0: begin
          red_nxt = cv_r; green_nxt = ct_r; blue_nxt = cp_r;
        end
        SEC_1: begin
          red_nxt = cq_r; green_nxt = cv_r; blue_nxt = cp_r;
        end
        SEC_2: begin
          red_nxt = cp_r; green_nxt = cv_r; blue_nxt = ct_r;
        end
        SEC_3: begin
          red_nxt = cp_r; green_nxt = cq_r; blue_nxt = cv_r;
        end
        SEC_4: begin
          red_nxt = ct_r; green_nxt = cp_r; blue_nxt = cv_r;
        end
        default: begin
          red_nxt = cv_r; green_nxt = cp_r; blue_nxt = cq_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s5) begin
      red_r    <= red_nxt;
      green_r  <= green_nxt;
      blue_r   <= blue_nxt;
      alpha5_r <= alpha4_r;
    end
  end

  assign red       = red_r;
  assign green     = green_r;
  assign blue      = blue_r;
  assign alpha_out = alpha5_r;
endmodule

// File: design/hsv_to_rgb_pixel_top.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel_top
// HSV to RGB pixel converter, five-stage pipeline with alpha pass-through.
// ----------------------------------------------------------------------------
// Converts one HSV pixel (Q16 fixed point, 1.0 = 65536) to 8-bit RGB per
// clock. Hue split, saturation products, brightness products, channel
// scaling and sector routing each hold one register stage.
// Throughput is one item per cycle while the output side takes results; a
// stalled output holds its item and the stages behind it fill up, so bubbles
// are squeezed out before in_ch.ready drops. Zero saturation yields grey;
// hue of 1.0 or more uses the last sector mapping. Alpha is carried unchanged.
`include "hsv_to_rgb_pixel_top_assert.svh"

module hsv_to_rgb_pixel_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  hsvp_in_if.sink     in_ch,
  hsvp_out_if.source  out_ch
);
  import hsvp_pkg::*;

  localparam int DW = ((FRAC_BITS > IN_W) ? FRAC_BITS : IN_W) + 2;
  localparam int PW = IN_W + 1 + DW;

  hsvp_adv_t         adv;
  logic [4:0]        vld_r, vld_nxt;
  logic              in_fire, out_fire;

  hsvp_sector_t         sec1, sec3;
  logic [FRAC_BITS-1:0] frac1;
  logic [IN_W-1:0]      sat1, val1, val3;
  logic [CHAN_W-1:0]    alpha1, alpha3;
  logic signed [PW-1:0] p3, q3, t3;
  logic                 grey3;

  // A stage loads when it is empty or its contents move on.
  always_comb begin
    adv.s5 = !vld_r[4] || out_ch.ready;
    adv.s4 = !vld_r[3] || adv.s5;
    adv.s3 = !vld_r[2] || adv.s4;
    adv.s2 = !vld_r[1] || adv.s3;
    adv.s1 = !vld_r[0] || adv.s2;

    vld_nxt[0] = adv.s1 ? in_ch.valid : vld_r[0];
    vld_nxt[1] = adv.s2 ? vld_r[0]    : vld_r[1];
    vld_nxt[2] = adv.s3 ? vld_r[1]    : vld_r[2];
    vld_nxt[3] = adv.s4 ? vld_r[2]    : vld_r[3];
    vld_nxt[4] = adv.s5 ? vld_r[3]    : vld_r[4];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ch.ready  = adv.s1;
  assign out_ch.valid = vld_r[4];
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_fire     = out_ch.valid && out_ch.ready;

  hsvp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .adv_s1     (adv.s1),
    .hue        (in_ch.hue),
    .saturation (in_ch.saturation),
    .brightness (in_ch.brightness),
    .alpha_in   (in_ch.alpha_in),
    .sec        (sec1),
    .frac       (frac1),
    .sat        (sat1),
    .val        (val1),
    .alpha      (alpha1)
  );

  hsvp_terms #(.FRAC_BITS(FRAC_BITS)) u_terms (
    .clk       (clk),
    .adv       (adv),
    .sec_in    (sec1),
    .frac      (frac1),
    .sat       (sat1),
    .val_in    (val1),
    .alpha_in  (alpha1),
    .p         (p3),
    .q         (q3),
    .t         (t3),
    .val_out   (val3),
    .grey      (grey3),
    .sec_out   (sec3),
    .alpha_out (alpha3)
  );

  hsvp_chan #(.FRAC_BITS(FRAC_BITS)) u_chan (
    .clk       (clk),
    .adv       (adv),
    .p         (p3),
    .q         (q3),
    .t         (t3),
    .val       (val3),
    .grey      (grey3),
    .sec       (sec3),
    .alpha_in  (alpha3),
    .red       (out_ch.red),
    .green     (out_ch.green),
    .blue      (out_ch.blue),
    .alpha_out (out_ch.alpha_out)
  );

  `HSVP_ASSERT_IMP(a_full_when_blocked, !in_ch.ready, &vld_r,
    "input blocked while a pipeline stage is empty")
  `HSVP_ASSERT_NXT(a_item_reaches_out, vld_r[3] && adv.s5, vld_r[4],
    "item lost between scaling and output stage")
  `HSVP_ASSERT_NXT(a_occupancy, 1'b1,
    $countones(vld_r) == $countones($past(vld_r)) + $past(in_fire) - $past(out_fire),
    "pipeline occupancy does not match accepted and delivered items")
endmodule
